// ----- src/ethernet_ip_arp_rx_classifier_top_defines.svh -----
// Assertion macros shared by the receive classifier.
`ifndef ETHERNET_IP_ARP_RX_CLASSIFIER_TOP_DEFINES_SVH
`define ETHERNET_IP_ARP_RX_CLASSIFIER_TOP_DEFINES_SVH
// Assert that an implication holds on every clock edge outside reset.
`define EARC_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Assert that a condition leads to another in the following cycle.
`define EARC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

// ----- src/earc_pkg.sv -----
// Types and constants of the Ethernet IPv4 and ARP receive classifier.
package earc_pkg;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } earc_in_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic [15:0] trimmed_length;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [1:0]  udp_match_index;
    logic        echo_request;
    logic        icmp_deliver;
  } earc_out_t;

  // Frame summary handed from the capture front end to the decision back end.
  typedef struct packed {
    logic [15:0] len;
    logic        is_arp;
    logic        is_ip;
    logic        arp_format_ok;
    logic [15:0] arp_opcode;
    logic [47:0] sender_mac;
    logic [31:0] source_ip;
    logic [31:0] target_ip;
    logic        version_ok;
    logic        frag_ok;
    logic        sum_ok;
    logic [15:0] ip_total_length;
    logic [7:0]  protocol;
    logic [15:0] udp_dest_port;
    logic [7:0]  icmp_type;
  } earc_sum_t;

  localparam logic [2:0] CFG_LOCAL_IP = 3'd0;
  localparam logic [2:0] CFG_UDP_0    = 3'd1;
  localparam logic [2:0] CFG_UDP_1    = 3'd2;
  localparam logic [2:0] CFG_UDP_2    = 3'd3;
  localparam logic [2:0] CFG_UDP_3    = 3'd4;
  localparam logic [2:0] CFG_ICMP_ON  = 3'd5;

  localparam logic [15:0] ETYPE_ARP = 16'h0806;
  localparam logic [15:0] ETYPE_IP  = 16'h0800;
  localparam logic [15:0] ETH_HDR   = 16'd14;
  localparam logic [15:0] ARP_MIN   = 16'd42;
  localparam logic [15:0] IP_MIN    = 16'd34;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [7:0]  ICMP_ECHO  = 8'd8;

  localparam logic [3:0] V_SHORT     = 4'd0;
  localparam logic [3:0] V_UNKNOWN   = 4'd1;
  localparam logic [3:0] V_ARP_BAD   = 4'd2;
  localparam logic [3:0] V_ARP_NOT   = 4'd3;
  localparam logic [3:0] V_ARP_REQ   = 4'd4;
  localparam logic [3:0] V_ARP_REP   = 4'd5;
  localparam logic [3:0] V_ARP_BADOP = 4'd6;
  localparam logic [3:0] V_IP_BADLEN = 4'd7;
  localparam logic [3:0] V_IP_BADHDR = 4'd8;
  localparam logic [3:0] V_IP_NOT    = 4'd9;
  localparam logic [3:0] V_ICMP      = 4'd10;
  localparam logic [3:0] V_UDP_MATCH = 4'd11;
  localparam logic [3:0] V_UDP_NONE  = 4'd12;
  localparam logic [3:0] V_IP_OTHER  = 4'd13;

  // ARP fixed format bytes at offsets 14 to 19.
  function automatic logic [7:0] arp_fmt(input logic [2:0] i);
    case (i)
      3'd0: arp_fmt = 8'h00;
      3'd1: arp_fmt = 8'h01;
      3'd2: arp_fmt = 8'h08;
      3'd3: arp_fmt = 8'h00;
      3'd4: arp_fmt = 8'd6;
      3'd5: arp_fmt = 8'd4;
      default: arp_fmt = 8'h00;
    endcase
  endfunction

endpackage

// ----- src/ethernet_ip_arp_rx_classifier_top.sv -----
// Top level of the Ethernet IPv4 and ARP receive classifier.
//
//  channel | direction | handshake             | word
//  in_     | input     | in_valid / in_ready   | one frame byte and last mark
//  out_    | output    | out_valid / out_ready | one verdict per frame
//  cfg_    | input     | cfg_valid / cfg_ready | register index and data
//
// One byte is taken per cycle while in_ready is high; the capture registers update as each byte arrives.
// A verdict passes from the capture summary register through a four-entry queue to the decision output register.
// Input stalls only when the queue holds three or more pending frame summaries.
// Reset is synchronous and active low; it clears the frame state, configuration, queue pointers and valid flags.
`include "ethernet_ip_arp_rx_classifier_top_defines.svh"
module ethernet_ip_arp_rx_classifier_top #(
  parameter int NUM_UDP_PORTS = 4,
  parameter int LEN_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  earc_pkg::earc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output earc_pkg::earc_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import earc_pkg::*;

  logic [31:0] local_ip_r;
  logic [15:0] port_r [4];
  logic        icmp_on_r;
  logic        in_take;
  logic        sum_valid, q_valid, q_take;
  earc_sum_t   sum_w, q_data;
  logic [2:0]  q_count;
  logic [4*16-1:0] ports_flat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r <= '0;
      port_r <= '{default: '0};
      icmp_on_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index) inside
        CFG_LOCAL_IP: local_ip_r <= cfg_data;
        [CFG_UDP_0:CFG_UDP_3]: port_r[2'(cfg_index - CFG_UDP_0)] <= cfg_data[15:0];
        CFG_ICMP_ON: icmp_on_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign ports_flat = {port_r[3], port_r[2], port_r[1], port_r[0]};

  // Room for a summary in flight plus one just captured.
  assign in_ready = q_count < 3'd3;
  assign in_take  = in_valid && in_ready;

  earc_capture #(.LEN_WIDTH(LEN_WIDTH)) u_capture (
    .clk, .rst_n, .byte_valid(in_take), .byte_in(in_data),
    .sum_valid, .sum_out(sum_w)
  );

  earc_queue u_queue (
    .clk, .rst_n, .wr_en(sum_valid), .wr_data(sum_w),
    .rd_valid(q_valid), .rd_en(q_take), .rd_data(q_data), .count(q_count)
  );

  earc_decide #(.NUM_UDP_PORTS(NUM_UDP_PORTS)) u_decide (
    .clk, .rst_n, .sum_valid(q_valid), .sum_take(q_take), .sum_in(q_data),
    .local_ip(local_ip_r), .udp_ports(ports_flat), .icmp_on(icmp_on_r),
    .out_valid, .out_ready, .out_data
  );

  `EARC_ASSERT_NEXT(a_last_makes_summary, clk, rst_n, in_take && in_data.last_byte, sum_valid)
  `EARC_ASSERT_IMP(a_queue_bound, clk, rst_n, 1'b1, q_count <= 3'd4)
  `EARC_ASSERT_IMP(a_udp_idx, clk, rst_n, out_valid && out_data.verdict != V_UDP_MATCH,
                   out_data.udp_match_index == 2'd0)
endmodule

// ----- src/earc_capture.sv -----
// Front end: captures header fields byte by byte and summarizes each frame.
module earc_capture #(
  parameter int LEN_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  earc_pkg::earc_in_t byte_in,
  output logic              sum_valid,
  output earc_pkg::earc_sum_t sum_out
);
  import earc_pkg::*;

  localparam logic [LEN_WIDTH-1:0] LEN_MAX = {LEN_WIDTH{1'b1}};

  logic [LEN_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic        fmt_ok_r, fmt_ok_nxt;
  logic [15:0] op_r, op_nxt;
  logic [47:0] mac_r, mac_nxt;
  logic [31:0] sip_r, sip_nxt;
  logic [31:0] tip_r, tip_nxt;
  logic [3:0]  ver_r, ver_nxt;
  logic [15:0] frag_r, frag_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [20:0] hsum_r, hsum_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [15:0] port_r, port_nxt;
  logic [7:0]  icmp_r, icmp_nxt;
  logic        sum_valid_r;
  earc_sum_t   sum_r, sum_nxt;

  logic [7:0]  b;
  logic [LEN_WIDTH-1:0] pos;
  logic [16:0] fold1;
  logic [16:0] fold2;

  assign b   = byte_in.frame_byte;
  assign pos = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r; etype_nxt = etype_r; fmt_ok_nxt = fmt_ok_r; op_nxt = op_r;
    mac_nxt = mac_r; sip_nxt = sip_r; tip_nxt = tip_r; ver_nxt = ver_r;
    frag_nxt = frag_r; tlen_nxt = tlen_r; proto_nxt = proto_r; hsum_nxt = hsum_r;
    hi_nxt = hi_r; port_nxt = port_r; icmp_nxt = icmp_r;
    if (pos == LEN_WIDTH'(12)) etype_nxt = {b, 8'h00};
    if (pos == LEN_WIDTH'(13)) etype_nxt = {etype_r[15:8], b};
    if (pos >= LEN_WIDTH'(14)) begin
      if (etype_r == ETYPE_ARP) begin
        if (pos < LEN_WIDTH'(20) && b != arp_fmt(3'(pos - LEN_WIDTH'(14))))
          fmt_ok_nxt = 1'b0;
        if (pos == LEN_WIDTH'(20) || pos == LEN_WIDTH'(21)) op_nxt = {op_r[7:0], b};
        if (pos >= LEN_WIDTH'(22) && pos < LEN_WIDTH'(28)) mac_nxt = {mac_r[39:0], b};
        if (pos >= LEN_WIDTH'(28) && pos < LEN_WIDTH'(32)) sip_nxt = {sip_r[23:0], b};
        if (pos >= LEN_WIDTH'(38) && pos < LEN_WIDTH'(42)) tip_nxt = {tip_r[23:0], b};
      end else if (etype_r == ETYPE_IP) begin
        if (pos < LEN_WIDTH'(34)) begin
          if (!pos[0]) hi_nxt = b;
          else hsum_nxt = hsum_r + 21'({hi_r, b});
        end
        if (pos == LEN_WIDTH'(14)) ver_nxt = b[7:4];
        if (pos == LEN_WIDTH'(16) || pos == LEN_WIDTH'(17)) tlen_nxt = {tlen_r[7:0], b};
        if (pos == LEN_WIDTH'(20) || pos == LEN_WIDTH'(21)) frag_nxt = {frag_r[7:0], b};
        if (pos == LEN_WIDTH'(23)) proto_nxt = b;
        if (pos >= LEN_WIDTH'(26) && pos < LEN_WIDTH'(30)) sip_nxt = {sip_r[23:0], b};
        if (pos >= LEN_WIDTH'(30) && pos < LEN_WIDTH'(34)) tip_nxt = {tip_r[23:0], b};
        if (pos == LEN_WIDTH'(34)) icmp_nxt = b;
        if (pos == LEN_WIDTH'(36) || pos == LEN_WIDTH'(37)) port_nxt = {port_r[7:0], b};
      end
    end
    if (cnt_r != LEN_MAX) cnt_nxt = cnt_r + LEN_WIDTH'(1);
  end

  // End-around carry fold of the header sum as it stands after this byte.
  assign fold1 = 17'(hsum_nxt[15:0]) + 17'(hsum_nxt[20:16]);
  assign fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);

  always_comb begin
    sum_nxt.len             = 16'(cnt_nxt);
    sum_nxt.is_arp          = etype_nxt == ETYPE_ARP;
    sum_nxt.is_ip           = etype_nxt == ETYPE_IP;
    sum_nxt.arp_format_ok   = fmt_ok_nxt;
    sum_nxt.arp_opcode      = op_nxt;
    sum_nxt.sender_mac      = mac_nxt;
    sum_nxt.source_ip       = sip_nxt;
    sum_nxt.target_ip       = tip_nxt;
    sum_nxt.version_ok      = ver_nxt == 4'd4;
    sum_nxt.frag_ok         = frag_nxt[13:0] == 14'd0;
    sum_nxt.sum_ok          = fold2[15:0] == 16'hffff;
    sum_nxt.ip_total_length = tlen_nxt;
    sum_nxt.protocol        = proto_nxt;
    sum_nxt.udp_dest_port   = port_nxt;
    sum_nxt.icmp_type       = icmp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_valid && byte_in.last_byte)) begin
      cnt_r <= '0; etype_r <= '0; fmt_ok_r <= 1'b1; op_r <= '0; mac_r <= '0;
      sip_r <= '0; tip_r <= '0; ver_r <= '0; frag_r <= '0; tlen_r <= '0;
      proto_r <= '0; hsum_r <= '0; hi_r <= '0; port_r <= '0; icmp_r <= '0;
    end else if (byte_valid) begin
      cnt_r <= cnt_nxt; etype_r <= etype_nxt; fmt_ok_r <= fmt_ok_nxt; op_r <= op_nxt;
      mac_r <= mac_nxt; sip_r <= sip_nxt; tip_r <= tip_nxt; ver_r <= ver_nxt;
      frag_r <= frag_nxt; tlen_r <= tlen_nxt; proto_r <= proto_nxt; hsum_r <= hsum_nxt;
      hi_r <= hi_nxt; port_r <= port_nxt; icmp_r <= icmp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_valid_r <= 1'b0;
    end else begin
      sum_valid_r <= byte_valid && byte_in.last_byte;
    end
    if (byte_valid && byte_in.last_byte) sum_r <= sum_nxt;
  end

  assign sum_valid = sum_valid_r;
  assign sum_out   = sum_r;
endmodule

// ----- src/earc_queue.sv -----
// Small FIFO of frame summaries between the capture and decision stages.
module earc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  earc_pkg::earc_sum_t wr_data,
  output logic               rd_valid,
  input  logic               rd_en,
  output earc_pkg::earc_sum_t rd_data,
  output logic [2:0]         count
);
  import earc_pkg::*;

  earc_sum_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (rd_en) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr_en) - 3'(rd_en);
    end
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  assign rd_valid = cnt_r != 3'd0;
  assign rd_data  = mem_r[rp_r];
  assign count    = cnt_r;
endmodule

// ----- src/earc_decide.sv -----
// Back end: turns a frame summary into a verdict and holds it for the consumer.
module earc_decide #(
  parameter int NUM_UDP_PORTS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               sum_valid,
  output logic               sum_take,
  input  earc_pkg::earc_sum_t sum_in,
  input  logic [31:0]        local_ip,
  input  logic [4*16-1:0]    udp_ports,
  input  logic               icmp_on,
  output logic               out_valid,
  input  logic               out_ready,
  output earc_pkg::earc_out_t out_data
);
  import earc_pkg::*;

  logic      valid_r;
  earc_out_t res_r, res_nxt;
  logic      hit;
  logic [1:0] hit_idx;
  logic [15:0] want;

  always_comb begin
    hit = 1'b0;
    hit_idx = 2'd0;
    for (int i = NUM_UDP_PORTS - 1; i >= 0; i--) begin
      if (udp_ports[i*16 +: 16] != 16'd0 && udp_ports[i*16 +: 16] == sum_in.udp_dest_port) begin
        hit = 1'b1;
        hit_idx = 2'(i);
      end
    end
  end

  assign want = sum_in.ip_total_length + ETH_HDR;

  always_comb begin
    res_nxt = '0;
    res_nxt.trimmed_length = sum_in.len;
    if (sum_in.len < ETH_HDR) begin
      res_nxt.verdict = V_SHORT;
    end else if (sum_in.is_arp) begin
      res_nxt.sender_mac = sum_in.sender_mac;
      res_nxt.sender_ip  = sum_in.source_ip;
      if (sum_in.len < ARP_MIN || !sum_in.arp_format_ok) res_nxt.verdict = V_ARP_BAD;
      else if (local_ip == 32'd0 || sum_in.target_ip != local_ip) res_nxt.verdict = V_ARP_NOT;
      else if (sum_in.arp_opcode == 16'd1) res_nxt.verdict = V_ARP_REQ;
      else if (sum_in.arp_opcode == 16'd2) res_nxt.verdict = V_ARP_REP;
      else res_nxt.verdict = V_ARP_BADOP;
    end else if (sum_in.is_ip) begin
      res_nxt.sender_ip = sum_in.source_ip;
      // The 17-bit compare keeps a wrapped total length plus header correct.
      if (sum_in.len < IP_MIN ||
          17'(sum_in.len) < 17'(sum_in.ip_total_length) + 17'(ETH_HDR)) begin
        res_nxt.verdict = V_IP_BADLEN;
      end else begin
        res_nxt.trimmed_length = want;
        if (!sum_in.version_ok || !sum_in.frag_ok || !sum_in.sum_ok)
          res_nxt.verdict = V_IP_BADHDR;
        else if (local_ip != 32'd0 && sum_in.target_ip != local_ip &&
                 sum_in.target_ip != 32'hffff_ffff)
          res_nxt.verdict = V_IP_NOT;
        else if (sum_in.protocol == PROTO_ICMP) begin
          res_nxt.verdict = V_ICMP;
          res_nxt.echo_request = sum_in.icmp_type == ICMP_ECHO;
          res_nxt.icmp_deliver = icmp_on;
        end else if (sum_in.protocol == PROTO_UDP) begin
          res_nxt.verdict = hit ? V_UDP_MATCH : V_UDP_NONE;
          res_nxt.udp_match_index = hit ? hit_idx : 2'd0;
        end else begin
          res_nxt.verdict = V_IP_OTHER;
        end
      end
    end else begin
      res_nxt.verdict = V_UNKNOWN;
    end
  end

  assign sum_take = sum_valid && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sum_take) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
    if (sum_take) res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = res_r;
endmodule
